>>> hdl/dsv_pkg.sv
// ----------------------------------------------------------------------------
// Date string validator package
// Shared constants and the record that passes from the parser to the checker.
// ----------------------------------------------------------------------------
package dsv_pkg;

    localparam int unsigned YEAR_W     = 14;
    localparam int unsigned FIELD_W    = 7;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned DIGITS_W   = 3;

    localparam logic [YEAR_W-1:0]  MIN_YEAR_RESET = 14'd1901;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO      = 8'd48;
    localparam logic [CHAR_W-1:0]  CHAR_NINE      = 8'd57;
    localparam logic [CHAR_W-1:0]  CHAR_SLASH     = 8'd47;
    localparam logic [COUNT_W-1:0] COUNT_SAT      = 4'd11;
    localparam logic [COUNT_W-1:0] LEN_MIN        = 4'd8;
    localparam logic [COUNT_W-1:0] LEN_MAX        = 4'd10;

    localparam logic [FIELD_W-1:0] MONTH_FEB = 7'd2;
    localparam logic [FIELD_W-1:0] MONTH_APR = 7'd4;
    localparam logic [FIELD_W-1:0] MONTH_JUN = 7'd6;
    localparam logic [FIELD_W-1:0] MONTH_SEP = 7'd9;
    localparam logic [FIELD_W-1:0] MONTH_NOV = 7'd11;
    localparam logic [FIELD_W-1:0] MONTH_DEC = 7'd12;

    typedef struct packed {
        logic               fmt_ok;
        logic               leap;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_rec;

endpackage

>>> hdl/dsv_front.sv
// ----------------------------------------------------------------------------
// Date string validator parser
// Takes one character per cycle while i_accept is high, tracks the fields and
// emits a record on the final character of each string.
// ----------------------------------------------------------------------------
module dsv_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [dsv_pkg::CHAR_W-1:0]      i_char_code,
    input  logic                            i_last,
    output logic                            o_push,
    output dsv_pkg::t_rec                   o_rec
);

    typedef enum logic [1:0] {
        PH_DAY,
        PH_MONTH,
        PH_YEAR,
        PH_TRAIL
    } t_phase;

    t_phase                          r_phase,  n_phase;
    logic [dsv_pkg::COUNT_W-1:0]     r_count,  n_count;
    logic [dsv_pkg::DIGITS_W-1:0]    r_digits, n_digits;
    logic [dsv_pkg::FIELD_W-1:0]     r_day,    n_day;
    logic [dsv_pkg::FIELD_W-1:0]     r_month,  n_month;
    logic [dsv_pkg::YEAR_W-1:0]      r_year,   n_year;
    logic                            r_failed, n_failed;
    logic [3:0]                      r_prev,   n_prev;
    logic [1:0]                      r_cent,   n_cent;
    logic                            r_leap,   n_leap;

    logic       is_digit;
    logic [3:0] digit;
    logic [1:0] low_mod4;

    assign is_digit = (i_char_code >= dsv_pkg::CHAR_ZERO) && (i_char_code <= dsv_pkg::CHAR_NINE);
    assign digit    = i_char_code[3:0];
    assign low_mod4 = 2'({r_prev[0], 1'b0} + digit[1:0]);

    always_comb begin
        n_phase  = r_phase;
        n_digits = r_digits;
        n_day    = r_day;
        n_month  = r_month;
        n_year   = r_year;
        n_failed = r_failed;
        n_prev   = r_prev;
        n_cent   = r_cent;
        n_leap   = r_leap;
        n_count  = (r_count < dsv_pkg::COUNT_SAT) ? r_count + 4'd1 : r_count;

        if (!r_failed) begin
            case (r_phase)
                PH_DAY, PH_MONTH: begin
                    if (is_digit) begin
                        if (r_digits >= 3'd2) begin
                            n_failed = 1'b1;
                        end else begin
                            if (r_phase == PH_DAY) begin
                                n_day = 7'(r_day * 7'd10 + 7'(digit));
                            end else begin
                                n_month = 7'(r_month * 7'd10 + 7'(digit));
                            end
                            n_digits = r_digits + 3'd1;
                        end
                    end else if (i_char_code == dsv_pkg::CHAR_SLASH) begin
                        if (r_digits == 3'd0) begin
                            n_failed = 1'b1;
                        end else if (r_phase == PH_DAY) begin
                            if (r_day == 7'd0) begin
                                n_failed = 1'b1;
                            end else begin
                                n_phase  = PH_MONTH;
                                n_digits = 3'd0;
                            end
                        end else begin
                            if (r_month < 7'd1 || r_month > dsv_pkg::MONTH_DEC) begin
                                n_failed = 1'b1;
                            end else begin
                                n_phase  = PH_YEAR;
                                n_digits = 3'd0;
                            end
                        end
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_YEAR: begin
                    if (!is_digit) begin
                        n_failed = 1'b1;
                    end else begin
                        n_year   = 14'(r_year * 14'd10 + 14'(digit));
                        n_digits = r_digits + 3'd1;
                        case (r_digits)
                            3'd0: n_prev = digit;
                            3'd1: n_cent = low_mod4;
                            3'd2: n_prev = digit;
                            3'd3: begin
                                n_phase = PH_TRAIL;
                                if (r_prev == 4'd0 && digit == 4'd0) begin
                                    n_leap = (r_cent == 2'd0);
                                end else begin
                                    n_leap = (low_mod4 == 2'd0);
                                end
                            end
                            default: n_prev = r_prev;
                        endcase
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    assign o_push       = i_accept && i_last;
    assign o_rec.fmt_ok = !n_failed && (n_phase == PH_TRAIL)
                          && (n_count >= dsv_pkg::LEN_MIN) && (n_count <= dsv_pkg::LEN_MAX);
    assign o_rec.leap   = n_leap;
    assign o_rec.day    = n_day;
    assign o_rec.month  = n_month;
    assign o_rec.year   = n_year;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_phase  <= PH_DAY;
            r_count  <= '0;
            r_digits <= '0;
            r_day    <= '0;
            r_month  <= '0;
            r_year   <= '0;
            r_failed <= 1'b0;
            r_prev   <= '0;
            r_cent   <= '0;
            r_leap   <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_digits <= n_digits;
            r_day    <= n_day;
            r_month  <= n_month;
            r_year   <= n_year;
            r_failed <= n_failed;
            r_prev   <= n_prev;
            r_cent   <= n_cent;
            r_leap   <= n_leap;
        end
    end

endmodule

>>> hdl/dsv_queue.sv
// ----------------------------------------------------------------------------
// Date string validator record queue
// Two-entry queue that lets the parser and the checker stall independently.
// ----------------------------------------------------------------------------
module dsv_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dsv_pkg::t_rec  i_rec,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output dsv_pkg::t_rec  o_rec
);

    dsv_pkg::t_rec r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

>>> hdl/dsv_back.sv
// ----------------------------------------------------------------------------
// Date string validator checker
// Checks the format flag, the minimum year and the calendar rules on a parsed
// record and holds the result item in an output register until it is taken.
// ----------------------------------------------------------------------------
module dsv_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [dsv_pkg::YEAR_W-1:0]    i_min_year,
    input  logic                          i_rec_valid,
    input  dsv_pkg::t_rec                 i_rec,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_valid_res
);

    logic [dsv_pkg::FIELD_W-1:0] dim;
    logic                        n_res;
    logic                        r_out_valid;
    logic                        r_res;

    always_comb begin
        case (i_rec.month)
            dsv_pkg::MONTH_FEB: dim = i_rec.leap ? 7'd29 : 7'd28;
            dsv_pkg::MONTH_APR,
            dsv_pkg::MONTH_JUN,
            dsv_pkg::MONTH_SEP,
            dsv_pkg::MONTH_NOV: dim = 7'd30;
            default:            dim = 7'd31;
        endcase
    end

    assign n_res = i_rec.fmt_ok
                   && (i_rec.year >= i_min_year)
                   && (i_rec.month >= 7'd1) && (i_rec.month <= dsv_pkg::MONTH_DEC)
                   && (i_rec.day >= 7'd1) && (i_rec.day <= dim);

    assign o_pop       = i_rec_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_valid_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= i_rec_valid;
        end
        if (o_pop) begin
            r_res <= n_res;
        end
    end

endmodule

>>> hdl/date_string_validator_core.sv
// ----------------------------------------------------------------------------
// Date string validator core
// Checks day/month/year date strings, one character per item, against the
// Gregorian calendar and a programmable minimum year.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_char_code, i_last
// result    out        o_out_valid / i_out_stall o_valid_res
// config    in         i_cfg_we                  i_cfg_data (min_year)
//
// One character is taken every cycle while the record queue is not full; the
// parser updates its fields in one step. A result passes from the final
// character of a string via the two-entry record queue and output register.
// Reset is synchronous and sets the minimum year to 1901.
// The input stalls only while the record queue is full.
// ----------------------------------------------------------------------------
module date_string_validator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dsv_pkg::CHAR_W-1:0]    i_char_code,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_valid_res,
    input  logic                          i_cfg_we,
    input  logic [dsv_pkg::YEAR_W-1:0]    i_cfg_data
);

    logic [dsv_pkg::YEAR_W-1:0] r_min_year;
    logic                       accept;
    logic                       push;
    logic                       q_full;
    logic                       q_valid;
    logic                       pop;
    dsv_pkg::t_rec              push_rec;
    dsv_pkg::t_rec              head_rec;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= dsv_pkg::MIN_YEAR_RESET;
        end else if (i_cfg_we) begin
            r_min_year <= i_cfg_data;
        end
    end

    dsv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_code (i_char_code),
        .i_last      (i_last),
        .o_push      (push),
        .o_rec       (push_rec)
    );

    dsv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rec   (head_rec)
    );

    dsv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_min_year  (r_min_year),
        .i_rec_valid (q_valid),
        .i_rec       (head_rec),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_valid_res (o_valid_res)
    );

endmodule
